// File: rtl/assert_macros.svh
// Assertion macros used by the RTL top level, the one RTL file that carries checks.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

`endif

// File: rtl/bdq_pkg.sv
// Shared types, sizes and codes of the bounded deque with search.
// No dependencies.
package bdq_pkg;

    // DEPTH must be a power of two: ring indexes wrap by truncation.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int FUNC_W     = 2;
    localparam int STAT_W     = 2;

    // Command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [FUNC_W-1:0] OP_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        data_t             value;
    } cmd_t;

endpackage

// File: rtl/bdq_front.sv
// Front end: accepts input items, decodes the operation and registers a command.
// Depends on bdq_pkg.
module bdq_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bdq_pkg::FUNC_W-1:0]    s_func,
    input  logic signed [bdq_pkg::DATA_WIDTH-1:0] s_value,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output bdq_pkg::cmd_t                 cmd
);
    import bdq_pkg::*;

    logic cmd_valid_reg;
    logic cmd_valid_next;
    cmd_t cmd_reg;

    // Take a new item whenever the held command is empty or leaves this cycle.
    assign s_ready = !cmd_valid_reg || cmd_ready;

    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd_valid_reg && cmd_ready) begin
            cmd_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            cmd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            case (s_func)
                OP_APPEND: cmd_reg.op <= OP_APPEND;
                OP_INSERT: cmd_reg.op <= OP_INSERT;
                OP_REMOVE: cmd_reg.op <= OP_REMOVE;
                default:   cmd_reg.op <= OP_SEARCH;
            endcase
            cmd_reg.value <= s_value;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

// File: rtl/bdq_cmd_fifo.sv
// Short command queue between the front end and the execution back end.
// Depends on bdq_pkg.
module bdq_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  bdq_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output bdq_pkg::cmd_t pop_cmd
);
    import bdq_pkg::*;

    cmd_t              q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = cnt_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/bdq_back.sv
// Back end: ring buffer storage, front index and count, search sequencer and
// the result register. Depends on bdq_pkg.
module bdq_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  bdq_pkg::cmd_t                      cmd,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bdq_pkg::STAT_W-1:0]         m_status,
    output logic signed [bdq_pkg::DATA_WIDTH-1:0] m_removed_value,
    output logic [bdq_pkg::CNT_W-1:0]          m_found_position,
    output logic [bdq_pkg::CNT_W-1:0]          m_entry_count
);
    import bdq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    data_t mem [DEPTH];
    data_t rd_data_reg;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [CNT_W-1:0] chk_pos_reg, chk_pos_next;
    data_t            key_reg, key_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    data_t             out_removed_reg, out_removed_next;
    logic [CNT_W-1:0]  out_pos_reg, out_pos_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;

    logic             out_free;
    logic             is_full;
    logic             is_empty;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] count_dec;

    assign out_free  = !out_valid_reg || m_ready;
    assign is_full   = count_reg == CNT_W'(DEPTH);
    assign is_empty  = count_reg == '0;
    assign count_dec = count_reg - 1'b1;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;

    always_comb begin
        state_next       = state_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        chk_valid_next   = chk_valid_reg;
        chk_pos_next     = chk_pos_reg;
        key_next         = key_reg;
        wr_en            = 1'b0;
        wr_addr          = front_reg + count_reg[IDX_W-1:0];
        rd_addr          = front_reg + count_dec[IDX_W-1:0];
        out_valid_next   = out_valid_reg && !m_ready;
        out_status_next  = out_status_reg;
        out_removed_next = out_removed_reg;
        out_pos_next     = out_pos_reg;
        out_count_next   = out_count_reg;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    key_next         = cmd.value;
                    out_status_next  = ST_OK;
                    out_removed_next = '0;
                    out_pos_next     = '0;
                    out_count_next   = count_reg;
                    case (cmd.op)
                        OP_APPEND: begin
                            out_valid_next = 1'b1;
                            if (is_full) begin
                                out_status_next = ST_FULL;
                            end else begin
                                wr_en          = 1'b1;
                                count_next     = count_reg + 1'b1;
                                out_count_next = count_reg + 1'b1;
                            end
                        end
                        OP_INSERT: begin
                            out_valid_next = 1'b1;
                            if (is_full) begin
                                out_status_next = ST_FULL;
                            end else begin
                                // step the front back one slot, wrapping
                                wr_en          = 1'b1;
                                wr_addr        = front_reg - 1'b1;
                                front_next     = front_reg - 1'b1;
                                count_next     = count_reg + 1'b1;
                                out_count_next = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (is_empty) begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_EMPTY;
                            end else begin
                                count_next = count_dec;
                                state_next = S_RD;
                            end
                        end
                        default: begin
                            if (is_empty) begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_NOT_FOUND;
                            end else begin
                                idx_next       = '0;
                                chk_valid_next = 1'b0;
                                state_next     = S_SRCH;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                out_valid_next   = 1'b1;
                out_status_next  = ST_OK;
                out_removed_next = rd_data_reg;
                out_pos_next     = '0;
                out_count_next   = count_reg;
                state_next       = S_IDLE;
            end
            S_SRCH: begin
                // issue one read a cycle, compare its data in the next cycle
                rd_addr = front_reg + idx_reg[IDX_W-1:0];
                if (idx_reg != count_reg) begin
                    idx_next       = idx_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_pos_next   = idx_reg + 1'b1;
                end else begin
                    chk_valid_next = 1'b0;
                end
                if (chk_valid_reg) begin
                    if (rd_data_reg == key_reg) begin
                        out_valid_next   = 1'b1;
                        out_status_next  = ST_OK;
                        out_removed_next = '0;
                        out_pos_next     = chk_pos_reg;
                        out_count_next   = count_reg;
                        chk_valid_next   = 1'b0;
                        state_next       = S_IDLE;
                    end else if (chk_pos_reg == count_reg) begin
                        out_valid_next   = 1'b1;
                        out_status_next  = ST_NOT_FOUND;
                        out_removed_next = '0;
                        out_pos_next     = '0;
                        out_count_next   = count_reg;
                        chk_valid_next   = 1'b0;
                        state_next       = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_pos_reg     <= chk_pos_next;
        key_reg         <= key_next;
        out_status_reg  <= out_status_next;
        out_removed_reg <= out_removed_next;
        out_pos_reg     <= out_pos_next;
        out_count_reg   <= out_count_next;
    end

    // Entry storage: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= key_next;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_removed_value  = out_removed_reg;
    assign m_found_position = out_pos_reg;
    assign m_entry_count    = out_count_reg;

endmodule

// File: rtl/bounded_deque_with_search.sv
// Append and insert are taken at one item per cycle while the result port is not
// stalled; remove and search hold off new items until their result is registered,
// and the search walks the single read port. Reset (aresetn low, synchronous)
// empties the list and clears the queue; entry storage is not cleared.
`include "assert_macros.svh"

module bounded_deque_with_search (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [bdq_pkg::FUNC_W-1:0]            s_func,
    input  logic signed [bdq_pkg::DATA_WIDTH-1:0] s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [bdq_pkg::STAT_W-1:0]            m_status,
    output logic signed [bdq_pkg::DATA_WIDTH-1:0] m_removed_value,
    output logic [bdq_pkg::CNT_W-1:0]             m_found_position,
    output logic [bdq_pkg::CNT_W-1:0]             m_entry_count
);
    import bdq_pkg::*;

    logic fr_valid;
    logic fr_ready;
    cmd_t fr_cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    bdq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_value   (s_value),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd       (fr_cmd)
    );

    bdq_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_cmd   (fr_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    bdq_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (q_valid),
        .cmd_ready        (q_ready),
        .cmd              (q_cmd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_removed_value  (m_removed_value),
        .m_found_position (m_found_position),
        .m_entry_count    (m_entry_count)
    );

    `ASSERT_IMPL(a_count_bound, aclk, aresetn, m_valid,
        m_entry_count <= CNT_W'(DEPTH), "entry count beyond depth")
    `ASSERT_IMPL(a_full_count, aclk, aresetn, m_valid && m_status == ST_FULL,
        m_entry_count == CNT_W'(DEPTH), "full status with room left")
    `ASSERT_IMPL(a_empty_result, aclk, aresetn, m_valid && m_status == ST_EMPTY,
        m_entry_count == '0 && m_removed_value == '0, "underflow result not empty")
    `ASSERT_IMPL(a_pos_range, aclk, aresetn, m_valid && m_found_position != '0,
        m_status == ST_OK && m_found_position <= m_entry_count, "found position out of range")
    `ASSERT_IMPL(a_stall_queued, aclk, aresetn, !s_ready,
        q_valid && fr_valid, "input stalled with empty queue")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of bounded_deque_with_search: directed and random deque operations
// predicted by a behavioral ring-buffer deque and checked at the result port, item by item.
// Depends on bdq_pkg and the RTL top level.
module testbench;
    import bdq_pkg::*;

    localparam int    RANDOM_ITEMS   = 900;
    localparam int    TIMEOUT_CYCLES = 2000;
    localparam int    HOLD_CYCLES    = 80;
    localparam int    TAIL_CYCLES    = 40;
    localparam data_t MAX_VALUE      = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t MIN_VALUE      = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [STAT_W-1:0] status;
        data_t             removed;
        logic [CNT_W-1:0]  position;
        logic [CNT_W-1:0]  count;
    } outcome_t;

    typedef struct {
        logic [FUNC_W-1:0] func;
        data_t             value;
        bit                drain;
    } deque_op_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [FUNC_W-1:0] s_func  = OP_APPEND;
    data_t             s_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [STAT_W-1:0] m_status;
    data_t             m_removed_value;
    logic [CNT_W-1:0]  m_found_position;
    logic [CNT_W-1:0]  m_entry_count;

    // Behavioral copy of the deque
    data_t            deque_mem [DEPTH];
    logic [IDX_W-1:0] deque_front = '0;
    logic [CNT_W-1:0] deque_count = '0;

    deque_op_t op_queue[$];
    outcome_t  outcome_queue[$];
    data_t     value_pool[$];

    logic item_taken     = 1'b0;
    int   accepted_items = 0;
    int   results_seen   = 0;
    int   total_items    = 0;
    int   phase          = 0;
    int   mismatches     = 0;
    int   idle_cycles    = 0;
    int   hold_left      = 0;
    int   holds_done     = 0;
    int   shadow_count   = 0;

    bounded_deque_with_search i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_removed_value  (m_removed_value),
        .m_found_position (m_found_position),
        .m_entry_count    (m_entry_count)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic outcome_t deque_apply(logic [FUNC_W-1:0] op, data_t val);
        outcome_t         r;
        logic [IDX_W-1:0] slot;
        r = '0;
        case (op)
            OP_APPEND, OP_INSERT: begin
                if (deque_count == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (op == OP_APPEND) begin
                        slot = deque_front + deque_count[IDX_W-1:0];
                        deque_mem[slot] = val;
                    end else begin
                        deque_front = deque_front - 1'b1;
                        deque_mem[deque_front] = val;
                    end
                    deque_count = deque_count + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (deque_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    deque_count = deque_count - 1'b1;
                    slot = deque_front + deque_count[IDX_W-1:0];
                    r.removed = deque_mem[slot];
                end
            end
            default: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < deque_count; i++) begin
                    slot = deque_front + IDX_W'(i);
                    if (deque_mem[slot] == val) begin
                        r.position = CNT_W'(i + 1);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
        endcase
        r.count = deque_count;
        return r;
    endfunction

    function automatic data_t pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return $urandom;
        if (sel < 8)
            return data_t'($urandom_range(7)) - 4;  // narrow range to get duplicates
        if (sel == 8) begin
            case ($urandom_range(3))
                0: return MAX_VALUE;
                1: return MIN_VALUE;
                2: return '0;
                default: return '1;
            endcase
        end
        return data_t'(1) << $urandom_range(DATA_WIDTH - 1);
    endfunction

    // Queue an item and track how full the deque will be once it is applied
    task automatic add_item(logic [FUNC_W-1:0] func, data_t value);
        op_queue.push_back('{func, value, 1'b0});
        case (func)
            OP_APPEND, OP_INSERT: begin
                if (shadow_count < DEPTH)
                    shadow_count++;
                value_pool.push_back(value);
                if (value_pool.size() > DEPTH)
                    value_pool.delete(0);
            end
            OP_REMOVE: begin
                if (shadow_count > 0)
                    shadow_count--;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, what);
    endtask

    initial begin
        int                sel;
        bit                fill_mode;
        logic [FUNC_W-1:0] op;
        data_t             v;

        add_item(OP_REMOVE, '0);               // underflow on empty
        add_item(OP_SEARCH, '0);               // search on empty
        add_item(OP_APPEND, MAX_VALUE);
        add_item(OP_APPEND, MIN_VALUE);
        add_item(OP_INSERT, '1);               // front index wraps below zero
        add_item(OP_INSERT, '0);
        add_item(OP_APPEND, 5);
        add_item(OP_APPEND, 5);
        add_item(OP_SEARCH, 5);                // first of two matches
        add_item(OP_SEARCH, MIN_VALUE);
        add_item(OP_SEARCH, MAX_VALUE - 1);    // miss by the low bit only
        for (int i = 0; i < DEPTH - 6; i++)
            add_item((i % 2 == 0) ? OP_APPEND : OP_INSERT, $urandom);
        add_item(OP_APPEND, $urandom);         // dropped, list full
        add_item(OP_INSERT, $urandom);         // dropped, list full
        add_item(OP_SEARCH, '1);
        add_item(OP_REMOVE, $urandom);

        // Alternate between filling and draining so full and empty are hit often
        fill_mode = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(99);
            if (sel < 12)
                op = FUNC_W'($urandom_range(3));
            else if (sel < 30)
                op = OP_SEARCH;
            else if (fill_mode)
                op = (sel < 85) ? ($urandom_range(1) ? OP_APPEND : OP_INSERT) : OP_REMOVE;
            else
                op = (sel < 85) ? OP_REMOVE : ($urandom_range(1) ? OP_APPEND : OP_INSERT);
            if (op == OP_SEARCH && value_pool.size() != 0 && $urandom_range(9) < 6)
                v = value_pool[$urandom_range(value_pool.size() - 1)];
            else
                v = pick_value();
            add_item(op, v);
            if (fill_mode && shadow_count == DEPTH && $urandom_range(3) == 0)
                fill_mode = 1'b0;
            else if (!fill_mode && shadow_count == 0 && $urandom_range(3) == 0)
                fill_mode = 1'b1;
        end
        op_queue[300].drain = 1'b1;
        op_queue[800].drain = 1'b1;
        total_items = op_queue.size();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (op_queue.size() != 0 || s_valid || outcome_queue.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (outcome_queue.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", outcome_queue.size()));
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Driver: present the next item once the current one is taken
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || item_taken) begin
                if (op_queue.size() != 0 && !(op_queue[0].drain && outcome_queue.size() != 0)
                    && $urandom_range(99) >= ((phase == 0) ? 19 : (phase == 1) ? 59 : 0)) begin
                    s_func  <= op_queue[0].func;
                    s_value <= op_queue[0].value;
                    s_valid <= 1'b1;
                    op_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result-side ready, with long hold-offs to back the block up into its input
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (holds_done < 2 && accepted_items >= ((holds_done == 0) ? 150 : 700)) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= ((phase == 0) ? 59 : (phase == 1) ? 19 : 0);
        end
    end

    // Monitor: check results first, then predict the item taken at this edge
    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (outcome_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: status %0d count %0d",
                                              m_status, m_entry_count));
                end else begin
                    want = outcome_queue.pop_front();
                    if (m_status !== want.status || m_removed_value !== want.removed
                        || m_found_position !== want.position || m_entry_count !== want.count)
                        report_mismatch($sformatf({"result %0d: expected status %0d removed %0d",
                            " position %0d count %0d, got status %0d removed %0d position %0d",
                            " count %0d"}, results_seen, want.status, want.removed,
                            want.position, want.count, m_status, m_removed_value,
                            m_found_position, m_entry_count));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                outcome_queue.push_back(deque_apply(s_func, s_value));
                accepted_items <= accepted_items + 1;
                if (accepted_items + 1 >= 2 * total_items / 3)
                    phase <= 2;
                else if (accepted_items + 1 >= total_items / 3)
                    phase <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= TIMEOUT_CYCLES) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
